### rtl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared widths, codes, types and the digit encoder for the radix digit unit.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_W     = 31;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int POS_W       = 5;

    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 36;
    // a 31-bit value has at most 31 digits (base two)
    localparam int DIGIT_LIMIT = 31;

    // divider: dividend padded to a whole number of steps
    localparam int STEP_BITS   = 4;
    localparam int NUM_W       = 32;
    localparam int STEP_COUNT  = NUM_W / STEP_BITS;
    localparam int STEP_CNT_W  = $clog2(STEP_COUNT);

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;  // 'A'
    localparam logic [RADIX_W-1:0] DEC_MAX   = 6'd9;
    localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } t_back_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] rem);
        logic [CHAR_W-1:0] ch;
        if (rem > DEC_MAX) begin
            ch = CHAR_ALPHA + CHAR_W'(rem - DEC_BASE);
        end else begin
            ch = CHAR_ZERO + CHAR_W'(rem);
        end
        return ch;
    endfunction

endpackage

### rtl/itrd_front.sv
// ----------------------------------------------------------------------------
// itrd_front
// Takes items, drops those that give no digits, stages the rest for the queue.
// ----------------------------------------------------------------------------
module itrd_front
    import itrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [RADIX_W-1:0] i_radix,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output t_job               o_job
);

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;
    logic accept;
    logic useful;

    // zero value or a base outside two..thirty-six yields nothing
    assign useful = (i_value != '0)
                 && (i_radix >= RADIX_W'(RADIX_MIN))
                 && (i_radix <= RADIX_W'(RADIX_MAX));

    assign busy   = r_valid & i_q_stat.full;
    assign accept = start & ~busy;
    assign o_push = r_valid & ~i_q_stat.full;
    assign o_job  = r_job;

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (accept) begin
            n_valid = useful;
            n_job   = '{value: i_value, radix: i_radix};
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

### rtl/itrd_queue.sv
// ----------------------------------------------------------------------------
// itrd_queue
// Small circular queue of pending items between front and back.
// ----------------------------------------------------------------------------
module itrd_queue
    import itrd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];

    assign do_push = i_push & ~o_stat.full;
    assign do_pop  = i_pop & ~o_stat.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### rtl/itrd_back.sv
// ----------------------------------------------------------------------------
// itrd_back
// Iterative divider: peels one digit per pass, emits it with its position.
// ----------------------------------------------------------------------------
module itrd_back
    import itrd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output logic              o_digit_strobe,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic [POS_W-1:0]  o_digit_position,
    output logic              o_last_digit
);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [NUM_W-1:0]      r_num;
    logic [NUM_W-1:0]      n_num;
    logic [RADIX_W-1:0]    r_radix;
    logic [RADIX_W-1:0]    n_radix;
    logic [RADIX_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    n_rem;
    logic [STEP_CNT_W-1:0] r_step;
    logic [STEP_CNT_W-1:0] n_step;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic                  r_strobe;
    logic                  n_strobe;
    logic [CHAR_W-1:0]     r_char;
    logic [CHAR_W-1:0]     n_char;
    logic [POS_W-1:0]      r_out_pos;
    logic [POS_W-1:0]      n_out_pos;
    logic                  r_last;
    logic                  n_last;

    logic [NUM_W-1:0]      step_num;
    logic [RADIX_W-1:0]    step_rem;
    logic [RADIX_W:0]      trial;
    logic                  is_last;

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb begin
        step_num = r_num;
        step_rem = r_rem;
        trial    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial    = {step_rem, step_num[NUM_W-1]};
            step_num = {step_num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_radix}) begin
                step_rem    = RADIX_W'(trial - {1'b0, r_radix});
                step_num[0] = 1'b1;
            end else begin
                step_rem = trial[RADIX_W-1:0];
            end
        end
    end

    assign is_last = (step_num == '0) || (r_pos == POS_W'(DIGIT_LIMIT - 1));

    always_comb begin
        n_state   = r_state;
        n_num     = r_num;
        n_radix   = r_radix;
        n_rem     = r_rem;
        n_step    = r_step;
        n_pos     = r_pos;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_out_pos = r_out_pos;
        n_last    = r_last;
        o_pop     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_num   = {{(NUM_W - VALUE_W){1'b0}}, i_job.value};
                    n_radix = i_job.radix;
                    n_rem   = '0;
                    n_step  = '0;
                    n_pos   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_num  = step_num;
                n_rem  = step_rem;
                n_step = r_step + 1'b1;
                if (r_step == STEP_CNT_W'(STEP_COUNT - 1)) begin
                    n_strobe  = 1'b1;
                    n_char    = digit_char(step_rem);
                    n_out_pos = r_pos;
                    n_last    = is_last;
                    n_rem     = '0;
                    n_step    = '0;
                    n_pos     = r_pos + 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_num     <= n_num;
        r_radix   <= n_radix;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_pos     <= n_pos;
        r_char    <= n_char;
        r_out_pos <= n_out_pos;
        r_last    <= n_last;
    end

    assign o_digit_strobe   = r_strobe;
    assign o_digit_char     = r_char;
    assign o_digit_position = r_out_pos;
    assign o_last_digit     = r_last;

endmodule

### rtl/integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a 31-bit integer into ASCII digits of base 2..36, least
// significant digit first, one strobed result per digit.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------
//  item in   | start high, busy low    | i_value, i_radix
//  digit out | o_digit_strobe (1 cyc)  | o_digit_char, o_digit_position,
//            |                         | o_last_digit
//
//  each digit is peeled by the shared divider, 4 quotient bits per cycle,
//  over the whole padded dividend; the back end loads an item from the
//  queue, then divides once per digit; items first pass the front stage
//  a zero value or a base outside 2..36 produces no digits
//  reset clears the front stage, the queue and the divider control
//  the receiver cannot stall; busy rises only when the front stage holds
//  an item and the queue is full
//
module integer_to_radix_digits_unit
    import itrd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [RADIX_W-1:0] i_radix,
    output logic               o_digit_strobe,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic [POS_W-1:0]   o_digit_position,
    output logic               o_last_digit
);

    // front to queue
    logic    push;
    t_job    push_job;
    // queue to back
    logic    pop;
    t_job    head_job;
    t_q_stat q_stat;

    // classify and stage
    itrd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_value  (i_value),
        .i_radix  (i_radix),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decouples intake from the long conversion
    itrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // repeated division, one digit per pass
    itrd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (head_job),
        .i_q_stat         (q_stat),
        .o_pop            (pop),
        .o_digit_strobe   (o_digit_strobe),
        .o_digit_char     (o_digit_char),
        .o_digit_position (o_digit_position),
        .o_last_digit     (o_last_digit)
    );

endmodule

### rtl/itrd_checker.sv
// ----------------------------------------------------------------------------
// itrd_checker
// Port-level checks on the digit stream of the radix digit unit.
// ----------------------------------------------------------------------------
module itrd_checker
    import itrd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_digit_strobe,
    input logic [CHAR_W-1:0]  o_digit_char,
    input logic [POS_W-1:0]   o_digit_position,
    input logic               o_last_digit
);

    // digit is a legal ascii digit or capital letter
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_strobe |->
            ((o_digit_char >= 7'h30 && o_digit_char <= 7'h39) ||
             (o_digit_char >= 7'h41 && o_digit_char <= 7'h5A)))
        else $error("digit char out of range");

    // a non-final digit is followed by the next one a divider pass later
    a_next_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_strobe && !o_last_digit) |-> ##STEP_COUNT
            (o_digit_strobe && o_digit_position == $past(o_digit_position, STEP_COUNT) + 1'b1))
        else $error("missing or misnumbered next digit");

    // a digit past position zero continues an unfinished item
    a_pos_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_strobe && o_digit_position != '0) |->
            ($past(o_digit_strobe, STEP_COUNT) && !$past(o_last_digit, STEP_COUNT)))
        else $error("digit without predecessor");

    // nothing comes out and nothing is refused right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_digit_strobe && !busy))
        else $error("strobe or busy after reset");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_digit_strobe   (o_digit_strobe),
    .o_digit_char     (o_digit_char),
    .o_digit_position (o_digit_position),
    .o_last_digit     (o_last_digit)
);

### bench/tb_integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits_unit
// Self-checking bench for the radix digit unit: directed corner items, then
// random items, in gapless groups or with random sender gaps. Every strobed digit is checked
// against a model-side digit expansion kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits_unit
    import itrd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    // items sent in the random part, valid or not
    localparam int RANDOM_ITEMS = 150;
    // covers the worst item, 31 digits, plus the front stage
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [VALUE_W-1:0] VALUE_TOP = {VALUE_W{1'b1}};
    localparam logic [RADIX_W-1:0] RADIX_TOP = {RADIX_W{1'b1}};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_digit;

    // holds the digits still owed by the block, oldest first
    class digit_scoreboard;
        string       glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
        t_digit      owed_q[$];
        int unsigned errors = 0;

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // expand an accepted item into its digits, least significant first
        function void note_item(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
            int unsigned n;
            int unsigned base;
            int unsigned rem;
            int unsigned count;
            t_digit      d;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
                return;
            end
            n     = value;
            base  = radix;
            count = 0;
            while (n > 0 && count < DIGIT_LIMIT) begin
                rem    = n % base;
                n      = n / base;
                d.ch   = CHAR_W'(glyphs[rem]);
                d.pos  = POS_W'(count);
                // a 31-bit value never runs out of digit slots
                d.last = (n == 0);
                owed_q.push_back(d);
                count++;
            end
        endfunction

        task check_digit(logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos, logic last);
            t_digit want;
            if (owed_q.size() == 0) begin
                report($sformatf("digit 0x%0h pos %0d with none outstanding", ch, pos));
                return;
            end
            want = owed_q.pop_front();
            if (ch !== want.ch) begin
                report($sformatf("pos %0d char 0x%0h, want 0x%0h", want.pos, ch, want.ch));
            end
            if (pos !== want.pos) begin
                report($sformatf("position %0d, want %0d", pos, want.pos));
            end
            if (last !== want.last) begin
                report($sformatf("pos %0d last flag %b, want %b", want.pos, last, want.last));
            end
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] i_value;
    logic [RADIX_W-1:0] i_radix;
    logic               o_digit_strobe;
    logic [CHAR_W-1:0]  o_digit_char;
    logic [POS_W-1:0]   o_digit_position;
    logic               o_last_digit;

    digit_scoreboard sb = new();
    int unsigned     cycles = 0;

    integer_to_radix_digits_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_value          (i_value),
        .i_radix          (i_radix),
        .o_digit_strobe   (o_digit_strobe),
        .o_digit_char     (o_digit_char),
        .o_digit_position (o_digit_position),
        .o_last_digit     (o_last_digit)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // timeout guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // digits cannot be held off, so every strobe is checked on the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_digit_strobe) begin
            sb.check_digit(o_digit_char, o_digit_position, o_last_digit);
        end
    end

    // present one item and hold it until the block takes it
    task automatic drive_item(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
        start   <= 1'b1;
        i_value <= value;
        i_radix <= radix;
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.note_item(value, radix);
    endtask

    // drop start for a number of cycles; zero keeps items back to back
    task automatic hold_off(int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until every owed digit has come out
    task automatic drain();
        hold_off(1);
        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
    endtask

    // mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return $urandom_range(20, 300);
        end else if (roll < 8) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    task automatic send(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
        drive_item(value, radix);
        hold_off(pick_gap());
    endtask

    // spread values over all magnitudes so digit counts vary widely
    function automatic logic [VALUE_W-1:0] rand_value();
        int unsigned roll;
        int unsigned w;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return VALUE_TOP;
        end
        w = $urandom_range(1, VALUE_W);
        return VALUE_W'($urandom) >> (VALUE_W - w);
    endfunction

    function automatic logic [RADIX_W-1:0] rand_radix();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return RADIX_W'($urandom_range(0, RADIX_MIN - 1));
        end else if (roll < 3) begin
            return RADIX_W'($urandom_range(RADIX_MAX + 1, 2 ** RADIX_W - 1));
        end
        return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endfunction

    initial begin
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        int unsigned        sent;
        bit                 gapless;

        start   = 1'b0;
        i_value = '0;
        i_radix = '0;
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send('0, 6'd10);                     // zero value gives no digits
        send(31'd1, RADIX_W'(RADIX_MIN));    // single digit, lowest base
        send(VALUE_TOP, RADIX_W'(RADIX_MIN)); // longest run, 31 binary digits
        send(VALUE_TOP, RADIX_W'(RADIX_MAX)); // top value, top base
        send(31'd35, RADIX_W'(RADIX_MAX));   // the highest letter digit
        send(31'd36, RADIX_W'(RADIX_MAX));   // carries into a second digit
        send(31'd10, 6'd16);                 // first letter digit
        send(31'd9, 6'd10);                  // highest numeric digit
        send(31'd1234567890, 6'd10);
        send(31'h5555_5555, RADIX_W'(RADIX_MIN));
        send(31'h2AAA_AAAA, RADIX_W'(RADIX_MIN));
        send(31'd1, RADIX_W'(RADIX_MAX));
        send(31'd100, 6'd0);                 // base below two is rejected
        send(31'd100, 6'd1);
        send(31'd100, 6'd37);                // base above thirty-six is rejected
        send(VALUE_TOP, RADIX_TOP);
        send('0, 6'd0);
        send(31'd1295, 6'd35);
        send(31'h4000_0000, 6'd8);
        send(31'd65535, 6'd16);
        send(31'd7, 6'd3);
        drain();

        // random part, in groups that are either gapless or with random gaps
        sent    = 0;
        gapless = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 10 == 0) begin
                gapless = ($urandom_range(0, 3) == 0);
            end
            value = rand_value();
            radix = rand_radix();
            drive_item(value, radix);
            sent++;
            // sender waits out the block from time to time
            if (sent % 50 == 25) begin
                drain();
            end
            if (!gapless) begin
                hold_off(pick_gap());
            end
        end

        start <= 1'b0;
        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
        // catch any stray digit after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/itrd_pkg.sv
rtl/itrd_front.sv
rtl/itrd_queue.sv
rtl/itrd_back.sv
rtl/integer_to_radix_digits_unit.sv
rtl/itrd_checker.sv
bench/tb_integer_to_radix_digits_unit.sv
